>>> hdl/rllcm_pkg.sv
// shared types and constants for the running lcm block
// no dependencies; used by rllcm_div, rllcm_core and running_lcm_with_limit_top
package rllcm_pkg;

  // field widths
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned MULT_WIDTH  = 32;
  localparam int unsigned LIMIT_WIDTH = 16;
  localparam int unsigned PROD_WIDTH  = MULT_WIDTH + VALUE_WIDTH;
  localparam int unsigned CNT_WIDTH   = $clog2(MULT_WIDTH);

  // limit register value after reset
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(50);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_REM,
    ST_QUOT,
    ST_SAT,
    ST_FINISH
  } lcm_state_e;

  // status from the serial divider
  typedef struct packed {
    logic                   done;
    logic [MULT_WIDTH-1:0]  quotient;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_status_t;

  // one result item
  typedef struct packed {
    logic [MULT_WIDTH-1:0] multiple;
    logic                  exceeded;
    logic                  within_limit;
  } result_t;

endpackage

>>> hdl/rllcm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on rllcm_pkg
module rllcm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rllcm_pkg::MULT_WIDTH-1:0]    dividend_i,
  input  logic [rllcm_pkg::VALUE_WIDTH-1:0]   divisor_i,
  output rllcm_pkg::div_status_t              status_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [rllcm_pkg::CNT_WIDTH-1:0]     cnt_q, cnt_d;
  logic [rllcm_pkg::MULT_WIDTH-1:0]    quo_q, quo_d;
  logic [rllcm_pkg::VALUE_WIDTH-1:0]   rem_q, rem_d;
  logic [rllcm_pkg::VALUE_WIDTH-1:0]   div_q, div_d;
  logic [rllcm_pkg::VALUE_WIDTH:0]     shifted;
  logic [rllcm_pkg::VALUE_WIDTH:0]     diff;

  // shift in the next dividend bit and trial subtract
  assign shifted = {rem_q, quo_q[rllcm_pkg::MULT_WIDTH-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rllcm_pkg::CNT_WIDTH'(rllcm_pkg::MULT_WIDTH - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[rllcm_pkg::VALUE_WIDTH]) begin
        rem_d = diff[rllcm_pkg::VALUE_WIDTH-1:0];
        quo_d = {quo_q[rllcm_pkg::MULT_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[rllcm_pkg::VALUE_WIDTH-1:0];
        quo_d = {quo_q[rllcm_pkg::MULT_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign status_o.done      = done_q;
  assign status_o.quotient  = quo_q;
  assign status_o.remainder = rem_q;

endmodule

>>> hdl/rllcm_core.sv
// sequencer for euclid gcd, quotient, multiply and sticky limit check
// depends on rllcm_pkg and rllcm_div
module rllcm_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [rllcm_pkg::VALUE_WIDTH-1:0]   period_i,
  input  logic                                first_i,
  input  logic [rllcm_pkg::LIMIT_WIDTH-1:0]   limit_i,
  input  logic                                out_free_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  output rllcm_pkg::result_t                  result_o
);

  rllcm_pkg::lcm_state_e                state_q, state_d;
  logic [rllcm_pkg::MULT_WIDTH-1:0]     run_q, run_d;
  logic                                 stopped_q, stopped_d;
  logic [rllcm_pkg::MULT_WIDTH-1:0]     x_q, x_d;
  logic [rllcm_pkg::VALUE_WIDTH-1:0]    y_q, y_d;
  logic [rllcm_pkg::VALUE_WIDTH-1:0]    period_q, period_d;
  logic                                 first_q, first_d;
  logic [rllcm_pkg::PROD_WIDTH-1:0]     prod_q, prod_d;
  logic                                 div_start;
  logic [rllcm_pkg::MULT_WIDTH-1:0]     div_dividend;
  logic [rllcm_pkg::VALUE_WIDTH-1:0]    div_divisor;
  rllcm_pkg::div_status_t               div_status;
  logic [rllcm_pkg::MULT_WIDTH-1:0]     limit_ext;
  logic                                 over_limit;

  // shared serial divider
  rllcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status)
  );

  // limit compare on the running value
  assign limit_ext  = {{(rllcm_pkg::MULT_WIDTH-rllcm_pkg::LIMIT_WIDTH){1'b0}}, limit_i};
  assign over_limit = run_q > limit_ext;

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    run_d        = run_q;
    stopped_d    = stopped_q;
    x_d          = x_q;
    y_d          = y_q;
    period_d     = period_q;
    first_d      = first_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    div_dividend = x_q;
    div_divisor  = y_q;
    res_valid_o  = 1'b0;
    busy_o       = (state_q != rllcm_pkg::ST_IDLE);
    result_o.multiple     = run_q;
    result_o.exceeded     = (first_q ? 1'b0 : stopped_q) | over_limit;
    result_o.within_limit = (run_q != '0) && !over_limit;
    case (state_q)
      rllcm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          period_d = period_i;
          first_d  = first_i;
          x_d      = run_q;
          y_d      = period_i;
          if (first_i) begin
            run_d   = {{(rllcm_pkg::MULT_WIDTH-rllcm_pkg::VALUE_WIDTH){1'b0}}, period_i};
            state_d = rllcm_pkg::ST_FINISH;
          end else if (stopped_q) begin
            state_d = rllcm_pkg::ST_FINISH;
          end else if (run_q == '0 || period_i == '0) begin
            run_d   = '0;
            state_d = rllcm_pkg::ST_FINISH;
          end else begin
            state_d = rllcm_pkg::ST_GCD;
          end
        end
      end
      // one euclid step, or the final quotient once the remainder is zero
      rllcm_pkg::ST_GCD: begin
        div_start = 1'b1;
        if (y_q == '0) begin
          div_dividend = run_q;
          div_divisor  = x_q[rllcm_pkg::VALUE_WIDTH-1:0];
          state_d      = rllcm_pkg::ST_QUOT;
        end else begin
          state_d = rllcm_pkg::ST_REM;
        end
      end
      rllcm_pkg::ST_REM: begin
        if (div_status.done) begin
          x_d     = {{(rllcm_pkg::MULT_WIDTH-rllcm_pkg::VALUE_WIDTH){1'b0}}, y_q};
          y_d     = div_status.remainder;
          state_d = rllcm_pkg::ST_GCD;
        end
      end
      rllcm_pkg::ST_QUOT: begin
        if (div_status.done) begin
          prod_d  = {{rllcm_pkg::VALUE_WIDTH{1'b0}}, div_status.quotient}
                  * {{rllcm_pkg::MULT_WIDTH{1'b0}}, period_q};
          state_d = rllcm_pkg::ST_SAT;
        end
      end
      // saturate products that do not fit the result
      rllcm_pkg::ST_SAT: begin
        if (prod_q[rllcm_pkg::PROD_WIDTH-1:rllcm_pkg::MULT_WIDTH] != '0) begin
          run_d = '1;
        end else begin
          run_d = prod_q[rllcm_pkg::MULT_WIDTH-1:0];
        end
        state_d = rllcm_pkg::ST_FINISH;
      end
      // update the sticky flag and hand the result over
      rllcm_pkg::ST_FINISH: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          stopped_d   = result_o.exceeded;
          state_d     = rllcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rllcm_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rllcm_pkg::ST_IDLE;
      run_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_q     <= run_d;
      stopped_q <= stopped_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    period_q <= period_d;
    first_q  <= first_d;
    prod_q   <= prod_d;
  end

endmodule

>>> hdl/running_lcm_with_limit_top.sv
// top level of the running lcm block: config register, core and output register
// depends on rllcm_pkg and rllcm_core
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries period_i and first_i.
//   A request with first_i high starts a new set with period_i as the running
//   multiple; otherwise period_i is folded into the running lcm until the
//   running value passes the limit, after which periods are ignored.
//   Output channel (out_valid_o / out_stall_i) gives one result per request:
//   multiple_o, exceeded_o and within_limit_o.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the limit;
//   write only while no request is in flight.
// Sequencing:
//   One request at a time. A first, stopped or zero-operand request goes from
//   idle to the finish state. A combining request runs the euclid remainder
//   steps and the final quotient, each one divider run (start, one pass per
//   quotient bit, done), then multiply, saturate and finish. The core returns
//   to idle as the result is loaded into the output register.
// Reset:
//   Clears the running multiple and the sticky flag, sets the limit to 50.
// Output stall:
//   The result waits in the output register; the next request is accepted
//   meanwhile and its result is held in the core until the register frees.
module running_lcm_with_limit_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rllcm_pkg::VALUE_WIDTH-1:0]   period_i,
  input  logic                                first_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rllcm_pkg::MULT_WIDTH-1:0]    multiple_o,
  output logic                                exceeded_o,
  output logic                                within_limit_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rllcm_pkg::LIMIT_WIDTH-1:0]   cfg_data_i
);

  logic [rllcm_pkg::LIMIT_WIDTH-1:0] limit_q, limit_d;
  logic                              out_valid_q, out_valid_d;
  rllcm_pkg::result_t                out_q, out_d;
  rllcm_pkg::result_t                core_result;
  logic                              core_busy;
  logic                              core_res_valid;
  logic                              out_free;

  // config write channel, always ready
  assign cfg_ready_o = 1'b1;
  assign limit_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;

  // output register frees when empty or taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  rllcm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .period_i    (period_i),
    .first_i     (first_i),
    .limit_i     (limit_q),
    .out_free_i  (out_free),
    .busy_o      (core_busy),
    .res_valid_o (core_res_valid),
    .result_o    (core_result)
  );

  assign in_stall_o = core_busy;

  // output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (core_res_valid) begin
      out_valid_d = 1'b1;
      out_d       = core_result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= rllcm_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign multiple_o     = out_q.multiple;
  assign exceeded_o     = out_q.exceeded;
  assign within_limit_o = out_q.within_limit;

  // an accepted request keeps the core busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core not busy after accepting a request");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(multiple_o) &&
                                      $stable(exceeded_o) && $stable(within_limit_o)))
    else $error("stalled result changed");

  // results only appear after the core was working on a request
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_res_valid) |-> in_stall_o)
    else $error("result produced while core idle");

  // a zero multiple is never reported within the limit
  a_zero_not_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && multiple_o == '0) |-> !within_limit_o)
    else $error("zero multiple flagged within limit");

endmodule

>>> verif/tb_top.sv
// self-checking bench for running_lcm_with_limit_top: directed table, then random sets
// depends on rllcm_pkg and running_lcm_with_limit_top
`timescale 1ns / 1ps

module tb_top;

  localparam int TOTAL_ITEMS     = 1170;
  localparam int TAIL_ITEMS      = 150;
  localparam int PHASE_ITEMS     = 160;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int END_CYCLES      = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int N_DIRECTED      = 27;

  // kinds of rows in the directed table
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [rllcm_pkg::VALUE_WIDTH-1:0] value;
    logic                              first;
    logic [rllcm_pkg::MULT_WIDTH-1:0]  multiple;
    logic                              exceeded;
    logic                              within_limit;
  } dir_row_t;

  // directed requests; the limit is 50 after reset
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_TYPED,   16'd7,     1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd6,     1'b1, 32'd6,          1'b0, 1'b1},
    '{ROW_TYPED,   16'd4,     1'b0, 32'd12,         1'b0, 1'b1},
    '{ROW_TYPED,   16'd5,     1'b0, 32'd60,         1'b1, 1'b0},
    '{ROW_TYPED,   16'd3,     1'b0, 32'd60,         1'b1, 1'b0},
    '{ROW_TYPED,   16'd50,    1'b1, 32'd50,         1'b0, 1'b1},
    '{ROW_TYPED,   16'd1,     1'b0, 32'd50,         1'b0, 1'b1},
    '{ROW_TYPED,   16'd51,    1'b1, 32'd51,         1'b1, 1'b0},
    '{ROW_TYPED,   16'd10,    1'b1, 32'd10,         1'b0, 1'b1},
    '{ROW_TYPED,   16'd0,     1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd9,     1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_LIMIT,   16'd65535, 1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd65535, 1'b1, 32'd65535,      1'b0, 1'b1},
    '{ROW_TYPED,   16'd65534, 1'b0, 32'd4294770690, 1'b1, 1'b0},
    '{ROW_TYPED,   16'd46368, 1'b1, 32'd46368,      1'b0, 1'b1},
    '{ROW_PREDICT, 16'd28657, 1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd1,     1'b1, 32'd1,          1'b0, 1'b1},
    '{ROW_TYPED,   16'd65535, 1'b0, 32'd65535,      1'b0, 1'b1},
    '{ROW_PREDICT, 16'd32768, 1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_LIMIT,   16'd1,     1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd1,     1'b1, 32'd1,          1'b0, 1'b1},
    '{ROW_TYPED,   16'd1,     1'b0, 32'd1,          1'b0, 1'b1},
    '{ROW_TYPED,   16'd2,     1'b0, 32'd2,          1'b1, 1'b0},
    '{ROW_TYPED,   16'd2,     1'b1, 32'd2,          1'b1, 1'b0},
    '{ROW_LIMIT,   16'd0,     1'b0, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd0,     1'b1, 32'd0,          1'b0, 1'b0},
    '{ROW_TYPED,   16'd3,     1'b1, 32'd3,          1'b1, 1'b0}
  };

  logic                              clk_i;
  logic                              rst_ni     = 1'b0;
  logic                              in_valid   = 1'b0;
  logic [rllcm_pkg::VALUE_WIDTH-1:0] period     = '0;
  logic                              first      = 1'b0;
  logic                              out_stall  = 1'b0;
  logic                              cfg_valid  = 1'b0;
  logic [rllcm_pkg::LIMIT_WIDTH-1:0] cfg_data   = '0;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [rllcm_pkg::MULT_WIDTH-1:0]  multiple_o;
  logic                              exceeded_o;
  logic                              within_limit_o;
  logic                              cfg_ready_o;

  // predictor state and the limit it assumes
  logic [rllcm_pkg::MULT_WIDTH-1:0]  run_mult    = '0;
  logic                              run_stopped = 1'b0;
  logic [rllcm_pkg::LIMIT_WIDTH-1:0] limit_q     = rllcm_pkg::LIMIT_RESET;

  rllcm_pkg::result_t pending_results[$];
  int      n_sent      = 0;
  int      n_errors    = 0;
  int      idle_cycles = 0;
  int      stall_left  = 0;
  bit      quiet       = 1'b0;

  running_lcm_with_limit_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .period_i       (period),
    .first_i        (first),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .multiple_o     (multiple_o),
    .exceeded_o     (exceeded_o),
    .within_limit_o (within_limit_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  // clock and one reset pulse
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // euclid remainder loop
  function automatic logic [rllcm_pkg::MULT_WIDTH-1:0] euclid_gcd(
      input logic [rllcm_pkg::MULT_WIDTH-1:0] a,
      input logic [rllcm_pkg::MULT_WIDTH-1:0] b);
    logic [rllcm_pkg::MULT_WIDTH-1:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // lcm of running value and period, zero operands give zero, saturates at 32 bits
  function automatic logic [rllcm_pkg::MULT_WIDTH-1:0] fold_lcm(
      input logic [rllcm_pkg::MULT_WIDTH-1:0]  acc,
      input logic [rllcm_pkg::VALUE_WIDTH-1:0] p);
    logic [rllcm_pkg::MULT_WIDTH-1:0] g;
    logic [63:0]                      prod;
    if (acc == 0 || p == 0) return '0;
    g    = euclid_gcd(acc, rllcm_pkg::MULT_WIDTH'(p));
    prod = 64'(acc / g) * 64'(p);
    if (prod > 64'hFFFF_FFFF) return '1;
    return prod[rllcm_pkg::MULT_WIDTH-1:0];
  endfunction

  // advance the running lcm by one request and return its result
  function automatic rllcm_pkg::result_t predict_lcm_step(
      input logic [rllcm_pkg::VALUE_WIDTH-1:0] p,
      input logic f);
    rllcm_pkg::result_t r;
    if (f) begin
      run_mult    = rllcm_pkg::MULT_WIDTH'(p);
      run_stopped = run_mult > rllcm_pkg::MULT_WIDTH'(limit_q);
    end else if (!run_stopped) begin
      run_mult = fold_lcm(run_mult, p);
      if (run_mult > rllcm_pkg::MULT_WIDTH'(limit_q)) run_stopped = 1'b1;
    end
    r.multiple     = run_mult;
    r.exceeded     = run_stopped;
    r.within_limit = (run_mult != 0) && (run_mult <= rllcm_pkg::MULT_WIDTH'(limit_q));
    return r;
  endfunction

  // mostly small periods so sets run long, sometimes wide or powers of two
  function automatic logic [rllcm_pkg::VALUE_WIDTH-1:0] pick_period();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return rllcm_pkg::VALUE_WIDTH'($urandom_range(1, 12));
      6, 7:             return rllcm_pkg::VALUE_WIDTH'($urandom_range(1, 255));
      8:                return rllcm_pkg::VALUE_WIDTH'($urandom_range(1, 65535));
      default:          return rllcm_pkg::VALUE_WIDTH'(1)
                               << $urandom_range(0, rllcm_pkg::VALUE_WIDTH - 1);
    endcase
  endfunction

  // present one request, hold it until accepted, then record its expected result
  task automatic send_request(input logic [rllcm_pkg::VALUE_WIDTH-1:0] p, input logic f,
                              input logic use_typed, input rllcm_pkg::result_t typed_res);
    rllcm_pkg::result_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    period   <= p;
    first    <= f;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_lcm_step(p, f);
    pending_results.push_back(use_typed ? typed_res : pred);
    n_sent++;
    quiet = n_sent >= TOTAL_ITEMS - TAIL_ITEMS;
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // write the limit register while the block is idle
  task automatic write_limit(input logic [rllcm_pkg::LIMIT_WIDTH-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    limit_q = v;
  endtask

  // stimulus: directed table, then random phases under different limits
  initial begin
    logic [rllcm_pkg::LIMIT_WIDTH-1:0] lim;
    int                                phase_start;
    int                                set_len;
    int                                phase;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_LIMIT) begin
        write_limit(DIRECTED[i].value);
      end else begin
        send_request(DIRECTED[i].value, DIRECTED[i].first, DIRECTED[i].kind == ROW_TYPED,
                     {DIRECTED[i].multiple, DIRECTED[i].exceeded, DIRECTED[i].within_limit});
      end
    end

    phase = 0;
    while (n_sent < TOTAL_ITEMS) begin
      case (phase % 6)
        0:       lim = 16'd65535;
        1:       lim = rllcm_pkg::LIMIT_WIDTH'($urandom_range(2000, 65535));
        2:       lim = 16'd1;
        3:       lim = rllcm_pkg::LIMIT_WIDTH'($urandom_range(50, 2000));
        4:       lim = rllcm_pkg::LIMIT_WIDTH'($urandom_range(1, 65535));
        default: lim = rllcm_pkg::LIMIT_RESET;
      endcase
      write_limit(lim);
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS && n_sent < TOTAL_ITEMS) begin
        if ($urandom_range(0, 9) != 0) begin
          // a well-formed set: first request, then a run of periods to fold in
          send_request(pick_period(), 1'b1, 1'b0, '0);
          set_len = $urandom_range(1, 8);
          repeat (set_len) send_request(pick_period(), 1'b0, 1'b0, '0);
        end else begin
          // noise: any period, either marking
          send_request(rllcm_pkg::VALUE_WIDTH'($urandom_range(1, 65535)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: check accepted results, then decide the stall for the next cycle
  always @(posedge clk_i) begin
    rllcm_pkg::result_t exp_res;
    if (out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected result: multiple %0d exceeded %0b within %0b",
                   multiple_o, exceeded_o, within_limit_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (multiple_o !== exp_res.multiple || exceeded_o !== exp_res.exceeded ||
            within_limit_o !== exp_res.within_limit) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("mismatch: multiple %0d/%0d exceeded %0b/%0b within %0b/%0b (exp/got)",
                     exp_res.multiple, multiple_o, exp_res.exceeded, exceeded_o,
                     exp_res.within_limit, within_limit_o);
        end
      end
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted request, result or write
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
